[src/three_wire_spi_register_master_unit_assert.svh]
// assertion macros for the three-wire spi register master
`ifndef THREE_WIRE_SPI_REGISTER_MASTER_UNIT_ASSERT_SVH
`define THREE_WIRE_SPI_REGISTER_MASTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TWSPI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("twspi assertion failed");
`define TWSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("twspi assertion failed");
`else
`define TWSPI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TWSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/twspi_pkg.sv]
`default_nettype none
package twspi_pkg;

	localparam int NUM_DEVICES = 6;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_RAW   = 3'd3;
	localparam logic [2:0] REQ_GAIN  = 3'd4;
	localparam logic [2:0] REQ_ATTEN = 3'd5;

	localparam logic [2:0] DEV_PGA1 = 3'd2;
	localparam logic [2:0] DEV_PGA2 = 3'd3;
	localparam logic [2:0] DEV_ATT1 = 3'd4;
	localparam logic [2:0] DEV_ATT2 = 3'd5;

	localparam logic [7:0]  READ_CMD   = 8'h80;
	localparam logic [15:0] WRITE_ADDR_MAX = 16'h1FFF;
	localparam logic [7:0]  GAIN_FLAG  = 8'h80;
	localparam logic [7:0]  ATTEN_MAX  = 8'd31;
	localparam logic signed [7:0] GAIN_MIN = -8'sd10;
	localparam logic signed [7:0] GAIN_MAX = 8'sd32;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TX_LO,
		PH_TX_HI,
		PH_RX_LO,
		PH_RX_HI
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] bit_cnt;
		logic [1:0] byte_cnt;
		logic [1:0] byte_total;
		logic [7:0] rx_shift;
		logic       read_pending;
		logic [2:0] cur_dev;
		logic [7:0] last_read;
	} ctrl_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [2:0]        device_select;
		logic [15:0]       reg_address;
		logic [7:0]        write_data;
		logic signed [7:0] rx_gain;
		logic [7:0]        rx_atten;
		logic              rx_channel;
		logic              sdio_sample;
	} item_t;

	typedef struct packed {
		logic                   serial_clock;
		logic                   serial_data_out;
		logic                   data_drive_enable;
		logic [NUM_DEVICES-1:0] chip_select_n;
		logic [2:0]             active_device;
		logic                   busy_res;
		logic [7:0]             read_data;
		logic                   read_valid;
		logic                   address_error;
		logic                   request_ignored;
	} result_t;

endpackage
`default_nettype wire

[src/three_wire_spi_register_master_unit.sv]
// channel | direction | handshake          | payload
// request | in        | in_valid/in_stall   | req_type .. sdio_sample
// result  | out       | out_valid/out_stall | serial_clock .. request_ignored
// config  | in        | cfg_we              | cfg_wdata (addr16_mask)
//
// one request per cycle sustained while the result is not stalled, one result per request
// a request passes the input register, then the sequencer step into the result register
// arst_n clears the sequencer, the valid flags and addr16_mask (to 1)
// a stalled result holds; one more request is taken into the input register,
// then in_stall rises until the result is taken
`default_nettype none
`include "three_wire_spi_register_master_unit_assert.svh"
module three_wire_spi_register_master_unit import twspi_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [NUM_DEVICES-1:0] cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [2:0]             req_type,
	input  wire logic [2:0]             device_select,
	input  wire logic [15:0]            reg_address,
	input  wire logic [7:0]             write_data,
	input  wire logic signed [7:0]      rx_gain,
	input  wire logic [7:0]             rx_atten,
	input  wire logic                   rx_channel,
	input  wire logic                   sdio_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        serial_clock,
	output logic                        serial_data_out,
	output logic                        data_drive_enable,
	output logic [NUM_DEVICES-1:0]      chip_select_n,
	output logic [2:0]                  active_device,
	output logic                        busy_res,
	output logic [7:0]                  read_data,
	output logic                        read_valid,
	output logic                        address_error,
	output logic                        request_ignored
);

	logic [NUM_DEVICES-1:0] mask_q;
	item_t                  item_s1;
	logic                   valid_s1;
	ctrl_t                  ctrl_q;
	ctrl_t                  ctrl_next;
	logic [2:0][7:0]        tx_bytes_q;
	logic [2:0][7:0]        tx_bytes_next;
	result_t                res;
	result_t                res_s2;
	logic                   valid_s2;
	logic                   advance;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= NUM_DEVICES'(1);
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{req_type, device_select, reg_address, write_data,
				rx_gain, rx_atten, rx_channel, sdio_sample};
		end
	end

	twspi_step u_step (
		.ctrl          (ctrl_q),
		.tx_bytes      (tx_bytes_q),
		.addr16_mask   (mask_q),
		.item          (item_s1),
		.ctrl_next     (ctrl_next),
		.tx_bytes_next (tx_bytes_next),
		.res           (res)
	);

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{phase: PH_IDLE, default: '0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ctrl_q <= ctrl_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			tx_bytes_q <= tx_bytes_next;
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign serial_clock      = res_s2.serial_clock;
	assign serial_data_out   = res_s2.serial_data_out;
	assign data_drive_enable = res_s2.data_drive_enable;
	assign chip_select_n     = res_s2.chip_select_n;
	assign active_device     = res_s2.active_device;
	assign busy_res          = res_s2.busy_res;
	assign read_data         = res_s2.read_data;
	assign read_valid        = res_s2.read_valid;
	assign address_error     = res_s2.address_error;
	assign request_ignored   = res_s2.request_ignored;

	`TWSPI_ASSERT_IMPL(a_busy_one_cs, clk, arst_n, valid_s2 && res_s2.busy_res,
		$countones(res_s2.chip_select_n) == NUM_DEVICES - 1)
	`TWSPI_ASSERT_IMPL(a_rvalid_rx, clk, arst_n, valid_s2 && res_s2.read_valid,
		res_s2.busy_res && !res_s2.data_drive_enable && res_s2.serial_clock)
	`TWSPI_ASSERT_NEXT(a_hold_s2, clk, arst_n, valid_s2 && out_stall,
		valid_s2 && $stable(res_s2))
	`TWSPI_ASSERT_IMPL(a_idle_cs, clk, arst_n, valid_s2 && !res_s2.busy_res,
		&res_s2.chip_select_n && res_s2.serial_clock)

endmodule
`default_nettype wire

[src/twspi_step.sv]
`default_nettype none
module twspi_step import twspi_pkg::*; (
	input  wire ctrl_t                  ctrl,
	input  wire logic [2:0][7:0]        tx_bytes,
	input  wire logic [NUM_DEVICES-1:0] addr16_mask,
	input  wire item_t                  item,
	output ctrl_t                       ctrl_next,
	output logic [2:0][7:0]             tx_bytes_next,
	output result_t                     res
);

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	always_comb begin
		ctrl_t      w;
		logic [2:0] dev;
		logic       dev_ok;
		logic       hdr16;
		logic [7:0] code;
		logic [7:0] att;
		logic [1:0] bi;
		logic [1:0] bc_inc;
		logic [7:0] hdr0;
		w = ctrl;
		tx_bytes_next = tx_bytes;
		dev = item.device_select;
		dev_ok = 1'b0;
		hdr16 = 1'b0;
		code = 8'd0;
		att = 8'd0;
		bi = 2'd0;
		bc_inc = 2'd0;
		hdr0 = 8'd0;

		res.serial_clock = 1'b1;
		res.serial_data_out = 1'b0;
		res.data_drive_enable = 1'b0;
		res.chip_select_n = '1;
		res.busy_res = 1'b0;
		res.read_valid = 1'b0;
		res.address_error = 1'b0;
		res.request_ignored = 1'b0;

		if (item.req_type == REQ_GAIN) begin
			dev = item.rx_channel ? DEV_PGA2 : DEV_PGA1;
		end else if (item.req_type == REQ_ATTEN) begin
			dev = item.rx_channel ? DEV_ATT2 : DEV_ATT1;
		end
		for (int i = 0; i < NUM_DEVICES; i++) begin
			if (dev == 3'(i)) begin
				dev_ok = 1'b1;
				hdr16 = addr16_mask[i];
			end
		end

		if (item.req_type inside {[REQ_READ:REQ_ATTEN]}) begin
			if (ctrl.phase != PH_IDLE || !dev_ok) begin
				res.request_ignored = 1'b1;
			end else if (item.req_type == REQ_WRITE && item.reg_address > WRITE_ADDR_MAX) begin
				res.address_error = 1'b1;
			end else begin
				w.cur_dev = dev;
				w.bit_cnt = 3'd0;
				w.byte_cnt = 2'd0;
				w.rx_shift = 8'd0;
				w.phase = PH_TX_LO;
				w.read_pending = (item.req_type == REQ_READ);
				hdr0 = (item.req_type == REQ_READ) ? READ_CMD : 8'd0;
				case (item.req_type)
					REQ_READ, REQ_WRITE: begin
						if (hdr16) begin
							tx_bytes_next[0] = hdr0 | item.reg_address[15:8];
							tx_bytes_next[1] = item.reg_address[7:0];
							tx_bytes_next[2] = item.write_data;
							w.byte_total = (item.req_type == REQ_READ) ? 2'd2 : 2'd3;
						end else begin
							tx_bytes_next[0] = hdr0 | item.reg_address[7:0];
							tx_bytes_next[1] = item.write_data;
							w.byte_total = (item.req_type == REQ_READ) ? 2'd1 : 2'd2;
						end
					end
					REQ_RAW: begin
						tx_bytes_next[0] = item.write_data;
						w.byte_total = 2'd1;
					end
					REQ_GAIN: begin
						if (item.rx_gain >= GAIN_MIN && item.rx_gain <= GAIN_MAX) begin
							code = 8'(item.rx_gain - GAIN_MIN);
						end
						tx_bytes_next[0] = GAIN_FLAG | rev8({code[5:0], 2'b00});
						w.byte_total = 2'd1;
					end
					default: begin
						att = (item.rx_atten > ATTEN_MAX) ? ATTEN_MAX : item.rx_atten;
						tx_bytes_next[0] = {att[6:0], 1'b0};
						w.byte_total = 2'd1;
					end
				endcase
			end
		end

		res.active_device = w.cur_dev;
		if (w.phase != PH_IDLE) begin
			res.busy_res = 1'b1;
			for (int i = 0; i < NUM_DEVICES; i++) begin
				if (w.cur_dev == 3'(i)) begin
					res.chip_select_n[i] = 1'b0;
				end
			end
		end

		bi = (w.byte_cnt == 2'd3) ? 2'd2 : w.byte_cnt;
		bc_inc = w.byte_cnt + 2'd1;
		case (w.phase)
			PH_TX_LO: begin
				res.serial_data_out = tx_bytes_next[bi][3'd7 - w.bit_cnt];
				res.data_drive_enable = 1'b1;
				res.serial_clock = 1'b0;
				w.phase = PH_TX_HI;
			end
			PH_TX_HI: begin
				res.serial_data_out = tx_bytes_next[bi][3'd7 - w.bit_cnt];
				res.data_drive_enable = 1'b1;
				if (w.bit_cnt == 3'd7) begin
					w.bit_cnt = 3'd0;
					w.byte_cnt = bc_inc;
					if (bc_inc >= w.byte_total || bc_inc == 2'd3) begin
						w.phase = w.read_pending ? PH_RX_LO : PH_IDLE;
					end else begin
						w.phase = PH_TX_LO;
					end
				end else begin
					w.bit_cnt = w.bit_cnt + 3'd1;
					w.phase = PH_TX_LO;
				end
			end
			PH_RX_LO: begin
				res.serial_clock = 1'b0;
				w.rx_shift = {w.rx_shift[6:0], item.sdio_sample};
				w.phase = PH_RX_HI;
			end
			PH_RX_HI: begin
				if (w.bit_cnt == 3'd7) begin
					w.bit_cnt = 3'd0;
					w.last_read = w.rx_shift;
					w.read_pending = 1'b0;
					res.read_valid = 1'b1;
					w.phase = PH_IDLE;
				end else begin
					w.bit_cnt = w.bit_cnt + 3'd1;
					w.phase = PH_RX_LO;
				end
			end
			default: begin
			end
		endcase

		res.read_data = w.last_read;
		ctrl_next = w;
	end

endmodule
`default_nettype wire

[sim/tb_three_wire_spi_register_master_unit.sv]
`timescale 1ns / 1ps
module tb_three_wire_spi_register_master_unit;
	import twspi_pkg::*;

	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [NUM_DEVICES-1:0] cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	item_t                  request_bus = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   serial_clock;
	logic                   serial_data_out;
	logic                   data_drive_enable;
	logic [NUM_DEVICES-1:0] chip_select_n;
	logic [2:0]             active_device;
	logic                   busy_res;
	logic [7:0]             read_data;
	logic                   read_valid;
	logic                   address_error;
	logic                   request_ignored;
	result_t                observed;

	// sequencer state as predicted
	phase_t                 sq_phase = PH_IDLE;
	logic [2:0]             sq_bit = '0;
	logic [1:0]             sq_byte = '0;
	logic [1:0]             sq_total = '0;
	logic [7:0]             sq_tx [3];
	logic [7:0]             sq_rx = '0;
	logic                   sq_read_pending = 1'b0;
	logic [2:0]             sq_dev = '0;
	logic [7:0]             sq_last = '0;
	logic [NUM_DEVICES-1:0] mask_model = NUM_DEVICES'(1);

	result_t spi_expected [$];
	int      mismatches = 0;
	int      requests_sent = 0;
	int      hold_len = 0;
	int      hold_token = 0;
	int      hold_token_seen = 0;
	int      rx_hold = 0;
	int      result_gap = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;

	three_wire_spi_register_master_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(request_bus.req_type),
		.device_select(request_bus.device_select),
		.reg_address(request_bus.reg_address),
		.write_data(request_bus.write_data),
		.rx_gain(request_bus.rx_gain),
		.rx_atten(request_bus.rx_atten),
		.rx_channel(request_bus.rx_channel),
		.sdio_sample(request_bus.sdio_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.serial_clock(serial_clock),
		.serial_data_out(serial_data_out),
		.data_drive_enable(data_drive_enable),
		.chip_select_n(chip_select_n),
		.active_device(active_device),
		.busy_res(busy_res),
		.read_data(read_data),
		.read_valid(read_valid),
		.address_error(address_error),
		.request_ignored(request_ignored)
	);

	assign observed = {serial_clock, serial_data_out, data_drive_enable, chip_select_n,
		active_device, busy_res, read_data, read_valid, address_error, request_ignored};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [15:0] seen,
		input logic [15:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, seen, want);
	endtask

	function automatic logic [1:0] load_header(input logic [2:0] dev, input logic [15:0] addr,
		input logic [7:0] cmd);
		if (mask_model[dev]) begin
			sq_tx[0] = cmd | addr[15:8];
			sq_tx[1] = addr[7:0];
			return 2'd2;
		end
		sq_tx[0] = cmd | addr[7:0];
		return 2'd1;
	endfunction

	task automatic begin_transfer(input logic [2:0] dev, input logic [1:0] total,
		input logic rd);
		sq_dev = dev;
		sq_total = total;
		sq_read_pending = rd;
		sq_bit = '0;
		sq_byte = '0;
		sq_rx = '0;
		sq_phase = PH_TX_LO;
	endtask

	task automatic spi_step(input item_t it, output result_t r);
		logic [2:0] dev;
		logic [1:0] n;
		logic [1:0] bi;
		logic [7:0] code;
		logic [7:0] rev;
		logic [7:0] att;
		int         i;
		r = '0;
		r.serial_clock = 1'b1;
		r.chip_select_n = '1;
		if (it.req_type >= REQ_READ && it.req_type <= REQ_ATTEN) begin
			if (sq_phase != PH_IDLE) begin
				r.request_ignored = 1'b1;
			end else begin
				if (it.req_type <= REQ_RAW)
					dev = it.device_select;
				else if (it.req_type == REQ_GAIN)
					dev = it.rx_channel ? DEV_PGA2 : DEV_PGA1;
				else
					dev = it.rx_channel ? DEV_ATT2 : DEV_ATT1;
				if (int'(dev) >= NUM_DEVICES) begin
					r.request_ignored = 1'b1;
				end else begin
					case (it.req_type)
						REQ_READ: begin
							n = load_header(dev, it.reg_address, READ_CMD);
							begin_transfer(dev, n, 1'b1);
						end
						REQ_WRITE: begin
							if (it.reg_address > WRITE_ADDR_MAX) begin
								r.address_error = 1'b1;
							end else begin
								n = load_header(dev, it.reg_address, 8'h00);
								sq_tx[n] = it.write_data;
								begin_transfer(dev, n + 2'd1, 1'b0);
							end
						end
						REQ_RAW: begin
							sq_tx[0] = it.write_data;
							begin_transfer(dev, 2'd1, 1'b0);
						end
						REQ_GAIN: begin
							if (it.rx_gain < GAIN_MIN || it.rx_gain > GAIN_MAX)
								code = '0;
							else
								code = it.rx_gain - GAIN_MIN;
							code = code << 2;
							for (i = 0; i < 8; i++)
								rev[i] = code[7 - i];
							sq_tx[0] = GAIN_FLAG | rev;
							begin_transfer(dev, 2'd1, 1'b0);
						end
						default: begin
							att = (it.rx_atten > ATTEN_MAX) ? ATTEN_MAX : it.rx_atten;
							sq_tx[0] = att << 1;
							begin_transfer(dev, 2'd1, 1'b0);
						end
					endcase
				end
			end
		end
		if (sq_phase != PH_IDLE) begin
			r.busy_res = 1'b1;
			r.chip_select_n[sq_dev] = 1'b0;
			if (sq_phase == PH_TX_LO || sq_phase == PH_TX_HI) begin
				bi = (sq_byte < 2'd3) ? sq_byte : 2'd2;
				r.serial_data_out = sq_tx[bi][3'd7 - sq_bit];
				r.data_drive_enable = 1'b1;
				if (sq_phase == PH_TX_LO) begin
					r.serial_clock = 1'b0;
					sq_phase = PH_TX_HI;
				end else if (sq_bit == 3'd7) begin
					sq_bit = '0;
					sq_byte = sq_byte + 2'd1;
					if (sq_byte >= sq_total || sq_byte == 2'd3)
						sq_phase = sq_read_pending ? PH_RX_LO : PH_IDLE;
					else
						sq_phase = PH_TX_LO;
				end else begin
					sq_bit = sq_bit + 3'd1;
					sq_phase = PH_TX_LO;
				end
			end else if (sq_phase == PH_RX_LO) begin
				r.serial_clock = 1'b0;
				sq_rx = {sq_rx[6:0], it.sdio_sample};
				sq_phase = PH_RX_HI;
			end else if (sq_bit == 3'd7) begin
				sq_bit = '0;
				sq_last = sq_rx;
				sq_read_pending = 1'b0;
				r.read_valid = 1'b1;
				sq_phase = PH_IDLE;
			end else begin
				sq_bit = sq_bit + 3'd1;
				sq_phase = PH_RX_LO;
			end
		end
		r.active_device = sq_dev;
		r.read_data = sq_last;
	endtask

	function automatic item_t random_request();
		item_t it;
		it.req_type = 3'($urandom_range(1, 5));
		if ($urandom_range(0, 9) == 0)
			it.device_select = 3'($urandom_range(NUM_DEVICES, 7));
		else
			it.device_select = 3'($urandom_range(0, NUM_DEVICES - 1));
		it.reg_address = 16'($urandom);
		if (it.req_type == REQ_WRITE && $urandom_range(0, 3) != 0)
			it.reg_address = 16'($urandom_range(0, WRITE_ADDR_MAX));
		it.write_data = 8'($urandom);
		it.rx_gain = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 46) - 12);
		it.rx_atten = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40));
		it.rx_channel = 1'($urandom);
		it.sdio_sample = 1'($urandom);
		return it;
	endfunction

	function automatic item_t tick_item();
		item_t it;
		it = random_request();
		case ($urandom_range(0, 9))
			0: it.req_type = REQ_SPARE_A;
			1: it.req_type = REQ_SPARE_B;
			default: it.req_type = REQ_TICK;
		endcase
		return it;
	endfunction

	function automatic item_t request_of(input logic [2:0] kind, input logic [2:0] dev,
		input logic [15:0] addr, input logic [7:0] data);
		item_t it;
		it = random_request();
		it.req_type = kind;
		it.device_select = dev;
		it.reg_address = addr;
		it.write_data = data;
		return it;
	endfunction

	task automatic send_request(input item_t it);
		int      gap;
		result_t want;
		gap = tx_idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		request_bus <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		spi_step(it, want);
		spi_expected.push_back(want);
		if (!want.request_ignored)
			requests_sent++;
	endtask

	task automatic finish_transfer();
		while (sq_phase != PH_IDLE)
			send_request(tick_item());
	endtask

	task automatic run_transfer(input item_t it);
		send_request(it);
		finish_transfer();
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (spi_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_addr16_mask(input logic [NUM_DEVICES-1:0] value);
		finish_transfer();
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mask_model = value;
	endtask

	task automatic test_idle_ticks();
		item_t it;
		it = tick_item();
		it.req_type = REQ_TICK;
		send_request(it);
		it.req_type = REQ_SPARE_A;
		send_request(it);
		it.req_type = REQ_SPARE_B;
		send_request(it);
	endtask

	task automatic test_raw_bytes();
		run_transfer(request_of(REQ_RAW, 3'd0, 16'h0000, 8'h00));
		run_transfer(request_of(REQ_RAW, 3'd5, 16'hFFFF, 8'hFF));
		run_transfer(request_of(REQ_RAW, 3'd6, 16'h0000, 8'h5A));
		run_transfer(request_of(REQ_RAW, 3'd7, 16'h0000, 8'hA5));
	endtask

	task automatic test_register_write();
		run_transfer(request_of(REQ_WRITE, 3'd0, 16'h0000, 8'hA5));
		run_transfer(request_of(REQ_WRITE, 3'd1, WRITE_ADDR_MAX, 8'hFF));
		run_transfer(request_of(REQ_WRITE, 3'd2, WRITE_ADDR_MAX + 16'd1, 8'h3C));
		run_transfer(request_of(REQ_WRITE, 3'd0, 16'hFFFF, 8'h00));
	endtask

	task automatic test_register_read();
		run_transfer(request_of(REQ_READ, 3'd0, 16'hFFFF, 8'h00));
		run_transfer(request_of(REQ_READ, 3'd3, 16'h00FF, 8'h00));
		run_transfer(request_of(REQ_READ, 3'd6, 16'h1234, 8'h00));
	endtask

	task automatic test_gain_atten();
		logic signed [7:0] gains [6] = '{-8'sd128, -8'sd11, -8'sd10, 8'sd32, 8'sd33, 8'sd127};
		logic [7:0]        attens [4] = '{8'd0, 8'd31, 8'd32, 8'd255};
		item_t             it;
		int                i;
		for (i = 0; i < 6; i++) begin
			it = request_of(REQ_GAIN, 3'd0, 16'h0000, 8'h00);
			it.rx_gain = gains[i];
			it.rx_channel = 1'(i);
			run_transfer(it);
		end
		for (i = 0; i < 4; i++) begin
			it = request_of(REQ_ATTEN, 3'd0, 16'h0000, 8'h00);
			it.rx_atten = attens[i];
			it.rx_channel = 1'(i >> 1);
			run_transfer(it);
		end
	endtask

	task automatic test_busy_drop();
		item_t it;
		send_request(request_of(REQ_READ, 3'd4, 16'h0042, 8'h00));
		repeat (3) send_request(tick_item());
		send_request(request_of(REQ_RAW, 3'd1, 16'h0000, 8'h81));
		send_request(request_of(REQ_WRITE, 3'd2, 16'hFFFF, 8'h18));
		it = request_of(REQ_GAIN, 3'd0, 16'h0000, 8'h00);
		send_request(it);
		finish_transfer();
	endtask

	task automatic test_addr16_mask();
		logic [NUM_DEVICES-1:0] masks [4];
		int                     i;
		masks = '{'0, '1, NUM_DEVICES'(6'h2A), NUM_DEVICES'($urandom)};
		for (i = 0; i < 4; i++) begin
			write_addr16_mask(masks[i]);
			run_transfer(request_of(REQ_READ, 3'($urandom_range(0, 5)), 16'($urandom), 8'h00));
			run_transfer(request_of(REQ_WRITE, 3'($urandom_range(0, 5)),
				16'($urandom_range(0, WRITE_ADDR_MAX)), 8'($urandom)));
		end
	endtask

	task automatic test_back_pressure();
		hold_len = 200;
		hold_token++;
		repeat (3) run_transfer(random_request());
		wait_results_drained();
		repeat (2) run_transfer(random_request());
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		int target;
		int next_cfg;
		target = requests_sent + 500;
		next_cfg = requests_sent + 300;
		while (requests_sent < target) begin
			if (requests_sent >= next_cfg) begin
				case ($urandom_range(0, 3))
					0: write_addr16_mask('0);
					1: write_addr16_mask('1);
					default: write_addr16_mask(NUM_DEVICES'($urandom));
				endcase
				next_cfg = requests_sent + 300;
			end
			if ($urandom_range(0, 7) == 0) begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end
			send_request(random_request());
			while (sq_phase != PH_IDLE)
				send_request($urandom_range(0, 11) == 0 ? random_request() : tick_item());
			if ($urandom_range(0, 4) == 0)
				send_request(tick_item());
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// receiver: random stall per result, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_token != hold_token_seen) begin
			hold_token_seen = hold_token;
			rx_hold = hold_len;
		end
		if (out_valid && !out_stall)
			result_gap = rx_idle_on ? $urandom_range(0, 6) : 0;
		if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (result_gap > 0) begin
			result_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (spi_expected.size() == 0) begin
				report_mismatch("result with none expected", 16'(observed), 16'd0);
			end else begin
				want = spi_expected.pop_front();
				if (observed.serial_clock !== want.serial_clock)
					report_mismatch("serial_clock", 16'(observed.serial_clock),
						16'(want.serial_clock));
				if (observed.serial_data_out !== want.serial_data_out)
					report_mismatch("serial_data_out", 16'(observed.serial_data_out),
						16'(want.serial_data_out));
				if (observed.data_drive_enable !== want.data_drive_enable)
					report_mismatch("data_drive_enable", 16'(observed.data_drive_enable),
						16'(want.data_drive_enable));
				if (observed.chip_select_n !== want.chip_select_n)
					report_mismatch("chip_select_n", 16'(observed.chip_select_n),
						16'(want.chip_select_n));
				if (observed.active_device !== want.active_device)
					report_mismatch("active_device", 16'(observed.active_device),
						16'(want.active_device));
				if (observed.busy_res !== want.busy_res)
					report_mismatch("busy_res", 16'(observed.busy_res), 16'(want.busy_res));
				if (observed.read_data !== want.read_data)
					report_mismatch("read_data", 16'(observed.read_data), 16'(want.read_data));
				if (observed.read_valid !== want.read_valid)
					report_mismatch("read_valid", 16'(observed.read_valid),
						16'(want.read_valid));
				if (observed.address_error !== want.address_error)
					report_mismatch("address_error", 16'(observed.address_error),
						16'(want.address_error));
				if (observed.request_ignored !== want.request_ignored)
					report_mismatch("request_ignored", 16'(observed.request_ignored),
						16'(want.request_ignored));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_raw_bytes();
		test_register_write();
		test_register_read();
		test_gain_atten();
		test_busy_drop();
		test_addr16_mask();
		test_back_pressure();
		test_random_traffic();
		test_back_pressure();
		finish_transfer();
		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
